// ===== design/cld_pkg.sv =====
`default_nettype none

package cld_pkg;

    localparam int DEPTH_DEFAULT = 128;

    localparam logic       OP_KEY     = 1'b0;

    localparam logic [7:0] KEY_NUL    = 8'h00;
    localparam logic [7:0] KEY_CTRL_D = 8'h04;
    localparam logic [7:0] KEY_CTRL_H = 8'h08;
    localparam logic [7:0] KEY_LF     = 8'h0A;
    localparam logic [7:0] KEY_CR     = 8'h0D;
    localparam logic [7:0] KEY_CTRL_U = 8'h15;
    localparam logic [7:0] KEY_DEL    = 8'h7F;

    localparam logic [7:0] ERASE_MAX  = 8'hFF;

    localparam logic [2:0] STAT_NONE    = 3'd0;
    localparam logic [2:0] STAT_BYTE    = 3'd1;
    localparam logic [2:0] STAT_NEWLINE = 3'd2;
    localparam logic [2:0] STAT_EOF     = 3'd3;
    localparam logic [2:0] STAT_EMPTY   = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_KILL_RD,
        S_KILL_CHK,
        S_READ_CHK,
        S_OUT
    } state_t;

    typedef struct packed {
        logic       echo_valid;
        logic [7:0] echo_char;
        logic [7:0] erase_count;
        logic       line_committed;
        logic [7:0] read_char;
        logic [2:0] read_status;
    } res_t;

endpackage

`default_nettype wire

// ===== design/cld_ram.sv =====
`default_nettype none

module cld_ram #(
    parameter int DEPTH = cld_pkg::DEPTH_DEFAULT,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/console_line_discipline.sv =====
// Canonical console line editor over a ring of DEPTH bytes held in one RAM.
// Each item runs from IDLE through EXEC to OUT; a read that finds a byte passes READ_CHK,
// and Ctrl-U loops KILL_RD/KILL_CHK per erased byte, plus a final read of the newline if it stops there.
// One item is handled at a time (in_ready only in IDLE), and OUT waits for the output to
// be free; a new item is taken while the previous result still waits at the output register.
// Reset (rst_n, async, active low) clears all positions, the output valid and the FSM.
`default_nettype none

module console_line_discipline #(
    parameter int DEPTH = cld_pkg::DEPTH_DEFAULT
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       operation,
    input  wire logic [7:0] key_char,
    input  wire logic       fresh_read,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            echo_valid,
    output logic      [7:0] echo_char,
    output logic      [7:0] erase_count,
    output logic            line_committed,
    output logic      [7:0] read_char,
    output logic      [2:0] read_status
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] SLOT_LAST = AW'(DEPTH - 1);

    // position: wrap bit above the slot index, i.e. modulo 2*DEPTH
    typedef logic [AW:0] pos_t;

    function automatic pos_t pos_inc(input pos_t p);
        pos_t r;
        if (p[AW-1:0] == SLOT_LAST)
        begin
            r = {~p[AW], {AW{1'b0}}};
        end
        else
        begin
            r = {p[AW], p[AW-1:0] + 1'b1};
        end
        return r;
    endfunction

    function automatic pos_t pos_dec(input pos_t p);
        pos_t r;
        if (p[AW-1:0] == '0)
        begin
            r = {~p[AW], SLOT_LAST};
        end
        else
        begin
            r = {p[AW], p[AW-1:0] - 1'b1};
        end
        return r;
    endfunction

    function automatic logic pos_full(input pos_t e, input pos_t r);
        return (e[AW-1:0] == r[AW-1:0]) && (e[AW] != r[AW]);
    endfunction

    cld_pkg::state_t state_reg, state_next;
    pos_t            read_pos_reg, read_pos_next;
    pos_t            commit_pos_reg, commit_pos_next;
    pos_t            edit_pos_reg, edit_pos_next;
    logic            op_reg;
    logic [7:0]      key_reg;
    logic            fresh_reg;
    cld_pkg::res_t   res_reg, res_next;
    cld_pkg::res_t   out_reg;
    logic            out_valid_reg, out_valid_next;
    logic            out_load;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [7:0]      ram_wdata;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    logic [7:0]      ram_rdata;

    cld_ram #(
        .DEPTH(DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign in_ready = (state_reg == cld_pkg::S_IDLE);

    always_comb
    begin
        pos_t       edit_inc;
        pos_t       edit_dec;
        logic [7:0] c;
        state_next      = state_reg;
        read_pos_next   = read_pos_reg;
        commit_pos_next = commit_pos_reg;
        edit_pos_next   = edit_pos_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_load        = 1'b0;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_waddr       = edit_pos_reg[AW-1:0];
        ram_raddr       = read_pos_reg[AW-1:0];
        c               = (key_reg == cld_pkg::KEY_CR) ? cld_pkg::KEY_LF : key_reg;
        ram_wdata       = c;
        edit_inc        = pos_inc(edit_pos_reg);
        edit_dec        = pos_dec(edit_pos_reg);

        unique case (state_reg)
            cld_pkg::S_IDLE:
            begin
                res_next = '0;
                if (in_valid)
                begin
                    state_next = cld_pkg::S_EXEC;
                end
            end
            cld_pkg::S_EXEC:
            begin
                state_next = cld_pkg::S_OUT;
                if (op_reg == cld_pkg::OP_KEY)
                begin
                    if (key_reg == cld_pkg::KEY_CTRL_U)
                    begin
                        state_next = cld_pkg::S_KILL_RD;
                    end
                    else if (key_reg == cld_pkg::KEY_CTRL_H || key_reg == cld_pkg::KEY_DEL)
                    begin
                        if (edit_pos_reg != commit_pos_reg)
                        begin
                            edit_pos_next        = edit_dec;
                            res_next.erase_count = 8'd1;
                        end
                    end
                    else if (key_reg != cld_pkg::KEY_NUL &&
                             !pos_full(edit_pos_reg, read_pos_reg))
                    begin
                        ram_we              = 1'b1;
                        res_next.echo_valid = 1'b1;
                        res_next.echo_char  = c;
                        edit_pos_next       = edit_inc;
                        if (c == cld_pkg::KEY_LF || c == cld_pkg::KEY_CTRL_D ||
                            pos_full(edit_inc, read_pos_reg))
                        begin
                            commit_pos_next         = edit_inc;
                            res_next.line_committed = 1'b1;
                        end
                    end
                end
                else if (read_pos_reg == commit_pos_reg)
                begin
                    res_next.read_status = cld_pkg::STAT_EMPTY;
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = cld_pkg::S_READ_CHK;
                end
            end
            cld_pkg::S_KILL_RD:
            begin
                if (edit_pos_reg == commit_pos_reg)
                begin
                    state_next = cld_pkg::S_OUT;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = edit_dec[AW-1:0];
                    state_next = cld_pkg::S_KILL_CHK;
                end
            end
            cld_pkg::S_KILL_CHK:
            begin
                if (ram_rdata != cld_pkg::KEY_LF)
                begin
                    edit_pos_next = edit_dec;
                    if (res_reg.erase_count != cld_pkg::ERASE_MAX)
                    begin
                        res_next.erase_count = res_reg.erase_count + 8'd1;
                    end
                    state_next = cld_pkg::S_KILL_RD;
                end
                else
                begin
                    state_next = cld_pkg::S_OUT;
                end
            end
            cld_pkg::S_READ_CHK:
            begin
                state_next = cld_pkg::S_OUT;
                if (ram_rdata == cld_pkg::KEY_CTRL_D)
                begin
                    res_next.read_status = cld_pkg::STAT_EOF;
                    if (fresh_reg)
                    begin
                        read_pos_next = pos_inc(read_pos_reg);
                    end
                end
                else
                begin
                    read_pos_next        = pos_inc(read_pos_reg);
                    res_next.read_char   = ram_rdata;
                    res_next.read_status = (ram_rdata == cld_pkg::KEY_LF) ?
                                           cld_pkg::STAT_NEWLINE : cld_pkg::STAT_BYTE;
                end
            end
            cld_pkg::S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = cld_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cld_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= cld_pkg::S_IDLE;
            read_pos_reg   <= '0;
            commit_pos_reg <= '0;
            edit_pos_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            read_pos_reg   <= read_pos_next;
            commit_pos_reg <= commit_pos_next;
            edit_pos_reg   <= edit_pos_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (in_valid && in_ready)
        begin
            op_reg    <= operation;
            key_reg   <= key_char;
            fresh_reg <= fresh_read;
        end
        if (out_load)
        begin
            out_reg <= res_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign echo_valid     = out_reg.echo_valid;
    assign echo_char      = out_reg.echo_char;
    assign erase_count    = out_reg.erase_count;
    assign line_committed = out_reg.line_committed;
    assign read_char      = out_reg.read_char;
    assign read_status    = out_reg.read_status;

`ifndef NO_ASSERTIONS
    a_erase_only: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && erase_count != 8'd0) |->
        (!echo_valid && read_status == cld_pkg::STAT_NONE))
        else $error("erase reported together with echo or read status");

    a_commit_echo: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && line_committed) |-> echo_valid)
        else $error("line committed without a stored byte");

    a_read_keeps_edit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cld_pkg::S_READ_CHK) |=>
        ($stable(edit_pos_reg) && $stable(commit_pos_reg)))
        else $error("read item moved edit or commit position");

    a_kill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cld_pkg::S_KILL_CHK) |-> (edit_pos_reg != commit_pos_reg))
        else $error("line kill walked past the committed position");

    a_ram_write_key: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == cld_pkg::S_EXEC && op_reg == cld_pkg::OP_KEY))
        else $error("ring written outside a keyboard item");
`endif

endmodule

`default_nettype wire

// ===== tb/console_line_discipline_tb.sv =====
`default_nettype none

module console_line_discipline_tb;

    localparam logic       OP_READ    = ~cld_pkg::OP_KEY;
    localparam logic [7:0] RING_FULL  = 8'(cld_pkg::DEPTH_DEFAULT);
    localparam int         RANDOM_ITEMS = 1750;
    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         HOLDOFF_AT   = 600;
    localparam int         HOLDOFF_LEN  = 500;

    typedef struct {
        bit         drain_pause;
        logic       op;
        logic [7:0] ch;
        logic       fresh;
    } console_item_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       operation = cld_pkg::OP_KEY;
    logic [7:0] key_char = cld_pkg::KEY_NUL;
    logic       fresh_read = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       echo_valid;
    logic [7:0] echo_char;
    logic [7:0] erase_count;
    logic       line_committed;
    logic [7:0] read_char;
    logic [2:0] read_status;

    console_line_discipline i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .key_char       (key_char),
        .fresh_read     (fresh_read),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .echo_valid     (echo_valid),
        .echo_char      (echo_char),
        .erase_count    (erase_count),
        .line_committed (line_committed),
        .read_char      (read_char),
        .read_status    (read_status)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // shadow of the line buffer and its three positions (mod 2*DEPTH)
    logic [7:0] line_ring [cld_pkg::DEPTH_DEFAULT];
    logic [7:0] rd_pos = '0;
    logic [7:0] cm_pos = '0;
    logic [7:0] ed_pos = '0;

    console_item_t console_items [$];
    cld_pkg::res_t expected_responses [$];
    console_item_t drive_item;

    int  err_cnt = 0;
    int  cycle_cnt = 0;
    int  results_seen = 0;
    int  n_keys = 0;
    int  n_reads = 0;
    int  n_commits = 0;
    int  n_erases = 0;
    int  n_eofs = 0;
    int  n_empty = 0;

    bit  drain_wait = 1'b0;
    int  gap_left = 0;
    int  burst_left = 1;
    int  ready_pct = 100;
    int  hold_left = 0;
    bit  holdoff_done = 1'b0;

    initial
    begin
        for (int i = 0; i < cld_pkg::DEPTH_DEFAULT; i++)
        begin
            line_ring[i] = '0;
        end
    end

    function automatic cld_pkg::res_t predict_line_edit(logic op, logic [7:0] ch,
                                                        logic fresh);
        cld_pkg::res_t r;
        logic [7:0]    c;
        logic [7:0]    prev;
        logic [7:0]    fill;
        r = '0;
        r.read_status = cld_pkg::STAT_NONE;
        if (op == cld_pkg::OP_KEY)
        begin
            n_keys++;
            if (ch == cld_pkg::KEY_CTRL_U)
            begin
                prev = ed_pos - 8'd1;
                while (ed_pos != cm_pos && line_ring[prev[6:0]] != cld_pkg::KEY_LF)
                begin
                    ed_pos = prev;
                    if (r.erase_count != cld_pkg::ERASE_MAX)
                        r.erase_count = r.erase_count + 8'd1;
                    prev = ed_pos - 8'd1;
                end
            end
            else if (ch == cld_pkg::KEY_CTRL_H || ch == cld_pkg::KEY_DEL)
            begin
                if (ed_pos != cm_pos)
                begin
                    ed_pos = ed_pos - 8'd1;
                    r.erase_count = 8'd1;
                end
            end
            else
            begin
                fill = ed_pos - rd_pos;
                if (ch != cld_pkg::KEY_NUL && fill < RING_FULL)
                begin
                    c = (ch == cld_pkg::KEY_CR) ? cld_pkg::KEY_LF : ch;
                    r.echo_valid = 1'b1;
                    r.echo_char = c;
                    line_ring[ed_pos[6:0]] = c;
                    ed_pos = ed_pos + 8'd1;
                    fill = ed_pos - rd_pos;
                    if (c == cld_pkg::KEY_LF || c == cld_pkg::KEY_CTRL_D || fill == RING_FULL)
                    begin
                        cm_pos = ed_pos;
                        r.line_committed = 1'b1;
                        n_commits++;
                    end
                end
            end
            if (r.erase_count != 8'd0)
                n_erases++;
        end
        else
        begin
            n_reads++;
            if (rd_pos == cm_pos)
            begin
                r.read_status = cld_pkg::STAT_EMPTY;
                n_empty++;
            end
            else
            begin
                c = line_ring[rd_pos[6:0]];
                if (c == cld_pkg::KEY_CTRL_D)
                begin
                    if (fresh)
                        rd_pos = rd_pos + 8'd1;
                    r.read_status = cld_pkg::STAT_EOF;
                    n_eofs++;
                end
                else
                begin
                    rd_pos = rd_pos + 8'd1;
                    r.read_char = c;
                    r.read_status = (c == cld_pkg::KEY_LF) ?
                                    cld_pkg::STAT_NEWLINE : cld_pkg::STAT_BYTE;
                end
            end
        end
        return r;
    endfunction

    task automatic push_key(input logic [7:0] ch);
        console_item_t it;
        it.drain_pause = 1'b0;
        it.op = cld_pkg::OP_KEY;
        it.ch = ch;
        it.fresh = 1'($urandom_range(0, 1));
        console_items.push_back(it);
    endtask

    task automatic push_read(input logic fresh);
        console_item_t it;
        it.drain_pause = 1'b0;
        it.op = OP_READ;
        it.ch = 8'($urandom_range(0, 255));
        it.fresh = fresh;
        console_items.push_back(it);
    endtask

    task automatic push_pause();
        console_item_t it;
        it.drain_pause = 1'b1;
        it.op = cld_pkg::OP_KEY;
        it.ch = cld_pkg::KEY_NUL;
        it.fresh = 1'b0;
        console_items.push_back(it);
    endtask

    task automatic push_fill_and_drain();
        int n;
        n = $urandom_range(cld_pkg::DEPTH_DEFAULT - 4, cld_pkg::DEPTH_DEFAULT + 8);
        for (int k = 0; k < n; k++)
            push_key(8'($urandom_range(8'h20, 8'h7e)));
        push_key(cld_pkg::KEY_CTRL_H);
        push_key(cld_pkg::KEY_CTRL_U);
        n = $urandom_range(cld_pkg::DEPTH_DEFAULT - 8, cld_pkg::DEPTH_DEFAULT + 12);
        for (int k = 0; k < n; k++)
            push_read(k == 0 || $urandom_range(0, 7) == 0);
    endtask

    task automatic push_line();
        int len;
        int pick;
        int n;
        len = $urandom_range(0, 24);
        for (int k = 0; k < len; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                push_key(cld_pkg::KEY_CTRL_H);
            else if (pick < 9)
                push_key(cld_pkg::KEY_DEL);
            else if (pick < 13)
                push_key(cld_pkg::KEY_CTRL_U);
            else if (pick < 18)
                push_key(8'($urandom_range(1, 255)));
            else
                push_key(8'($urandom_range(8'h20, 8'h7e)));
        end
        pick = $urandom_range(0, 99);
        if (pick < 40)
            push_key(cld_pkg::KEY_CR);
        else if (pick < 75)
            push_key(cld_pkg::KEY_LF);
        else if (pick < 90)
            push_key(cld_pkg::KEY_CTRL_D);
        n = $urandom_range(0, len + 4);
        for (int k = 0; k < n; k++)
            push_read(k == 0 || $urandom_range(0, 3) == 0);
    endtask

    task automatic push_noise();
        int n;
        n = $urandom_range(1, 10);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 1) == 0)
                push_key(8'($urandom_range(0, 255)));
            else
                push_read(1'($urandom_range(0, 1)));
        end
    endtask

    // sender: bursts of items separated by random gaps, holding at each drain pause until all results are back
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_responses.push_back(
                    predict_line_edit(operation, key_char, fresh_read));
            if (!in_valid || in_ready)
            begin
                if (drain_wait && expected_responses.size() == 0)
                    drain_wait = 1'b0;
                if (!drain_wait && console_items.size() > 0 && console_items[0].drain_pause)
                begin
                    void'(console_items.pop_front());
                    drain_wait = 1'b1;
                end
                if (drain_wait || console_items.size() == 0)
                begin
                    in_valid <= 1'b0;
                end
                else if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else
                begin
                    drive_item = console_items.pop_front();
                    operation  <= drive_item.op;
                    key_char   <= drive_item.ch;
                    fresh_read <= drive_item.fresh;
                    in_valid   <= 1'b1;
                    if (burst_left > 1)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            err_cnt++;
        end
    endtask

    // receiver: random stall density per window, plus one long hold-off
    always @(posedge clk)
    begin
        cld_pkg::res_t exp_r;
        cycle_cnt++;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_responses.size() == 0)
                begin
                    $error("result arrived with no item outstanding");
                    err_cnt++;
                end
                else
                begin
                    exp_r = expected_responses.pop_front();
                    check_field("echo_valid", exp_r.echo_valid, echo_valid);
                    check_field("echo_char", exp_r.echo_char, echo_char);
                    check_field("erase_count", exp_r.erase_count, erase_count);
                    check_field("line_committed", exp_r.line_committed, line_committed);
                    check_field("read_char", exp_r.read_char, read_char);
                    check_field("read_status", exp_r.read_status, read_status);
                end
            end
            if (cycle_cnt % 64 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: ready_pct = 100;
                    1: ready_pct = 75;
                    default: ready_pct = 35;
                endcase
            end
            if (!holdoff_done && results_seen >= HOLDOFF_AT && in_valid && !drain_wait)
            begin
                holdoff_done = 1'b1;
                hold_left = HOLDOFF_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) < ready_pct);
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT)
            @(posedge clk);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_cnt, expected_responses.size());
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int pick;
        int target;

        // directed: empty read, ignored and no-op keys, editing, kill, EOF cases
        push_read(1'b1);
        push_key(cld_pkg::KEY_NUL);
        push_key(cld_pkg::KEY_CTRL_H);
        push_key(cld_pkg::KEY_CTRL_U);
        push_key(cld_pkg::KEY_DEL);
        push_key("a");
        push_key("b");
        push_key("c");
        push_key(cld_pkg::KEY_CTRL_H);
        push_key(cld_pkg::KEY_DEL);
        push_key(8'hFF);
        push_key(8'h80);
        push_key(cld_pkg::KEY_CTRL_U);
        push_key("h");
        push_key(cld_pkg::KEY_CR);
        push_read(1'b1);
        push_read(1'b0);
        push_key(cld_pkg::KEY_CTRL_D);
        push_read(1'b0);
        push_read(1'b1);
        push_read(1'b1);
        push_key("z");
        push_key(cld_pkg::KEY_CTRL_D);
        push_read(1'b1);
        push_read(1'b0);
        push_read(1'b1);
        push_pause();

        target = console_items.size() + RANDOM_ITEMS;
        push_fill_and_drain();
        push_pause();
        while (console_items.size() < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 72)
                push_line();
            else if (pick < 92)
                push_noise();
            else if (pick < 94)
                push_fill_and_drain();
            else
                push_pause();
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (console_items.size() != 0 || drain_wait || in_valid ||
               expected_responses.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("Ran %0d keyboard items and %0d reads: %0d line commits, %0d erases,",
                 n_keys, n_reads, n_commits, n_erases);
        $display("%0d end-of-file reads, %0d empty reads, %0d results checked",
                 n_eofs, n_empty, results_seen);
        if (err_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
